@@ src/skgi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skgi_pkg
// Shared types and constants of the skip-gram index enumerator.
// ----------------------------------------------------------------------------
package skgi_pkg;

    localparam int OUT_WORDS = 8;
    localparam int WORD_W    = 8;
    localparam int LEN_W     = 4;
    localparam int COUNT_W   = 9;
    localparam int GRAM_W    = 4;
    localparam int SKIP_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRAM_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_LENGTHS = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } skgi_state_t;

    typedef logic [OUT_WORDS-1:0][WORD_W-1:0] gram_words_t;

    typedef struct packed {
        logic accept;
        logic advance;
        logic out_load;
        logic out_exhaust;
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;
        logic emit;
    } walk_status_t;

endpackage

@@ src/skgi_walk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skgi_walk
// Search stack and the shared move unit: one step-in or back-out per cycle while advance is asserted.
// ----------------------------------------------------------------------------
module skgi_walk #(
    parameter int MAX_GRAM  = 8,
    parameter int MAX_WORDS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  skgi_pkg::ctrl_cmd_t          cmd,
    input  logic                         restart,
    input  logic [skgi_pkg::COUNT_W-1:0] word_count,
    input  logic [skgi_pkg::GRAM_W-1:0]  gram,
    input  logic [skgi_pkg::SKIP_W-1:0]  skip_limit,
    input  logic                         all_lengths,
    output skgi_pkg::walk_status_t       status,
    output logic [skgi_pkg::LEN_W-1:0]   gram_length,
    output skgi_pkg::gram_words_t        words
);

    localparam int IW = $clog2(MAX_WORDS);
    localparam int SW = $clog2(MAX_WORDS + 1);
    localparam int DW = $clog2(MAX_GRAM + 1);
    localparam int AW = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
    localparam int CW = ((IW > skgi_pkg::SKIP_W) ? IW : skgi_pkg::SKIP_W) + 1;

    logic [IW-1:0] stack_reg [MAX_GRAM];
    logic [IW-1:0] stack_next [MAX_GRAM];
    logic [DW-1:0] depth_reg, depth_next;
    logic [IW-1:0] top_reg, top_next;
    logic [SW-1:0] words_reg, words_next;
    logic          active_reg, active_next;

    logic [DW-1:0] prev_addr;
    logic [DW-1:0] depth_up;
    logic [IW-1:0] prev;
    logic [IW-1:0] top_inc;
    logic [SW-1:0] count_clamped;
    logic          room;
    logic          fits;
    logic          gap_ok;
    logic          can_step;
    logic          len_ok;

    // top_reg mirrors stack[depth] whenever the depth is below MAX_GRAM
    assign prev_addr = depth_reg - 1'b1;
    assign depth_up  = depth_reg + 1'b1;
    assign prev      = (32'(prev_addr) < MAX_GRAM) ? stack_reg[prev_addr[AW-1:0]] : '0;
    assign top_inc   = top_reg + 1'b1;

    assign count_clamped = (32'(word_count) > MAX_WORDS) ? SW'(MAX_WORDS) : SW'(word_count);

    assign room   = (32'(depth_reg) < 32'(gram)) && (32'(depth_reg) < MAX_GRAM);
    assign fits   = (32'(top_reg) + 32'd1) < 32'(words_reg);
    assign gap_ok = (depth_reg == '0) || (top_reg < prev)
                    || ((CW'(top_reg) - CW'(prev)) <= CW'(skip_limit));
    assign can_step = room && fits && gap_ok;

    assign len_ok = (depth_reg != '0)
                    && (all_lengths ? (32'(depth_reg) <= 32'(gram))
                                    : (32'(depth_reg) == 32'(gram)));

    assign status.active = active_reg;
    assign status.emit   = active_reg && !can_step && len_ok;

    assign gram_length = skgi_pkg::LEN_W'(depth_reg);

    for (genvar i = 0; i < skgi_pkg::OUT_WORDS; i++) begin : g_word
        if (i < MAX_GRAM) begin : g_live
            assign words[i] = (32'(i) < 32'(depth_reg)) ? skgi_pkg::WORD_W'(stack_reg[i]) : '0;
        end
        else begin : g_none
            assign words[i] = '0;
        end
    end

    always_comb
    begin
        stack_next  = stack_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        words_next  = words_reg;
        active_next = active_reg;
        if (cmd.accept && restart)
        begin
            words_next = count_clamped;
            for (int i = 0; i < MAX_GRAM; i++)
            begin
                stack_next[i] = '0;
            end
            depth_next  = DW'(1);
            top_next    = '0;
            active_next = 32'(count_clamped) >= 32'(gram);
        end
        else if (cmd.advance && active_reg)
        begin
            if (can_step)
            begin
                // step in: take the next word at this level, seed the level below if it lies within the gram
                stack_next[depth_reg[AW-1:0]] = top_inc;
                depth_next = depth_up;
                if ((32'(depth_up) < 32'(gram)) && (32'(depth_up) < MAX_GRAM))
                begin
                    stack_next[depth_up[AW-1:0]] = top_inc;
                    top_next = top_inc;
                end
                else if (32'(depth_up) < MAX_GRAM)
                begin
                    // level below is not seeded and keeps its old entry
                    top_next = stack_reg[depth_up[AW-1:0]];
                end
            end
            else if (depth_reg == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                // back out one level
                depth_next = prev_addr;
                top_next   = prev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_GRAM; i++)
            begin
                stack_reg[i] <= '0;
            end
            depth_reg  <= DW'(1);
            top_reg    <= '0;
            words_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            stack_reg  <= stack_next;
            depth_reg  <= depth_next;
            top_reg    <= top_next;
            words_reg  <= words_next;
            active_reg <= active_next;
        end
    end

endmodule

@@ src/skgi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skgi_ctrl
// Sequencer: accepts an item, drives search moves until a gram or exhaustion.
// ----------------------------------------------------------------------------
module skgi_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   slot_free,
    input  skgi_pkg::walk_status_t status,
    output logic                   in_stall,
    output skgi_pkg::ctrl_cmd_t    cmd
);

    skgi_pkg::skgi_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skgi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = skgi_pkg::ST_WALK;
                end
            end
            skgi_pkg::ST_WALK:
            begin
                if ((!status.active || status.emit) && slot_free)
                begin
                    state_next = skgi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skgi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            skgi_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            skgi_pkg::ST_WALK:
            begin
                if (!status.active)
                begin
                    cmd.out_load    = slot_free;
                    cmd.out_exhaust = slot_free;
                end
                else if (status.emit)
                begin
                    // hold the back-out until the result register can take the item
                    cmd.advance  = slot_free;
                    cmd.out_load = slot_free;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skgi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/skip_gram_index_enumerator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skip_gram_index_enumerator_top
// Pull-driven skip-gram enumerator with configuration registers.
// ----------------------------------------------------------------------------
// Each input item returns one result item: the next gram of the depth-first
// walk or, once the walk is exhausted, an item with walk_done set. An item
// is accepted and then driven by search moves (a step in or a back-out),
// made by the single move unit in skgi_walk; the back-out that leaves an
// included gram also loads the result, and an exhausted result is loaded
// once the last move has cleared the walk's active flag. A run of back-outs
// near the end of a sentence can make the wait between grams longer. The
// block takes no new item while a walk is in progress, and waits when the
// result register still holds an untaken item. Configuration writes are
// taken in any cycle.
module skip_gram_index_enumerator_top #(
    parameter int MAX_GRAM  = 8,
    parameter int MAX_WORDS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           restart,
    input  logic [skgi_pkg::COUNT_W-1:0]   word_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           gram_valid,
    output logic                           walk_done,
    output logic [skgi_pkg::LEN_W-1:0]     gram_length,
    output logic [skgi_pkg::WORD_W-1:0]    word_a,
    output logic [skgi_pkg::WORD_W-1:0]    word_b,
    output logic [skgi_pkg::WORD_W-1:0]    word_c,
    output logic [skgi_pkg::WORD_W-1:0]    word_d,
    output logic [skgi_pkg::WORD_W-1:0]    word_e,
    output logic [skgi_pkg::WORD_W-1:0]    word_f,
    output logic [skgi_pkg::WORD_W-1:0]    word_g,
    output logic [skgi_pkg::WORD_W-1:0]    word_h,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [skgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [skgi_pkg::CFG_DAT_W-1:0] cfg_data
);

    logic [skgi_pkg::GRAM_W-1:0] gram_size_reg;
    logic [skgi_pkg::SKIP_W-1:0] skip_limit_reg;
    logic                        all_lengths_reg;
    logic [skgi_pkg::GRAM_W-1:0] gram_eff;

    skgi_pkg::ctrl_cmd_t    cmd;
    skgi_pkg::walk_status_t status;
    skgi_pkg::gram_words_t  walk_words;
    logic [skgi_pkg::LEN_W-1:0] walk_length;

    logic                       out_valid_reg;
    logic                       gram_valid_reg;
    logic                       walk_done_reg;
    logic [skgi_pkg::LEN_W-1:0] length_reg;
    skgi_pkg::gram_words_t      words_reg;
    logic                       slot_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gram_size_reg   <= skgi_pkg::GRAM_W'(2);
            skip_limit_reg  <= '0;
            all_lengths_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                skgi_pkg::REG_GRAM_SIZE:   gram_size_reg   <= cfg_data[skgi_pkg::GRAM_W-1:0];
                skgi_pkg::REG_SKIP_LIMIT:  skip_limit_reg  <= cfg_data[skgi_pkg::SKIP_W-1:0];
                skgi_pkg::REG_ALL_LENGTHS: all_lengths_reg <= cfg_data[0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign gram_eff = (32'(gram_size_reg) > MAX_GRAM) ? skgi_pkg::GRAM_W'(MAX_GRAM)
                                                       : gram_size_reg;

    assign slot_free = !out_valid_reg || !out_stall;

    skgi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .slot_free (slot_free),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    skgi_walk #(
        .MAX_GRAM  (MAX_GRAM),
        .MAX_WORDS (MAX_WORDS)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .restart     (restart),
        .word_count  (word_count),
        .gram        (gram_eff),
        .skip_limit  (skip_limit_reg),
        .all_lengths (all_lengths_reg),
        .status      (status),
        .gram_length (walk_length),
        .words       (walk_words)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_exhaust)
            begin
                gram_valid_reg <= 1'b0;
                walk_done_reg  <= 1'b1;
                length_reg     <= '0;
                words_reg      <= '0;
            end
            else
            begin
                gram_valid_reg <= 1'b1;
                walk_done_reg  <= 1'b0;
                length_reg     <= walk_length;
                words_reg      <= walk_words;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign gram_valid  = gram_valid_reg;
    assign walk_done   = walk_done_reg;
    assign gram_length = length_reg;
    assign word_a      = words_reg[0];
    assign word_b      = words_reg[1];
    assign word_c      = words_reg[2];
    assign word_d      = words_reg[3];
    assign word_e      = words_reg[4];
    assign word_f      = words_reg[5];
    assign word_g      = words_reg[6];
    assign word_h      = words_reg[7];

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for skip_gram_index_enumerator_top.
// A directed table covers reset state, short and clamped sentences, gram
// size extremes, all-lengths mode and register changes in mid-walk. It is
// followed by random phases of register settings, sentences and pulls. An
// in-bench gram walker predicts every result item, and the results are
// compared field by field under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_GRAM     = 8;
    localparam int MAX_WORDS    = 256;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TAIL_CYCLES  = 50;

    typedef struct packed {
        logic                             gram_valid;
        logic                             walk_done;
        logic [skgi_pkg::LEN_W-1:0]       gram_len;
        skgi_pkg::gram_words_t            words;
    } gram_result_t;

    // One directed step; an optional register load comes first. Typed grams
    // are runs of consecutive words starting at want_first.
    typedef struct packed {
        logic                             set_cfg;
        logic [skgi_pkg::GRAM_W-1:0]      gram;
        logic [skgi_pkg::SKIP_W-1:0]      skip;
        logic                             all;
        logic                             restart;
        logic [skgi_pkg::COUNT_W-1:0]     count;
        logic                             typed;
        logic                             want_gram;
        logic [skgi_pkg::LEN_W-1:0]       want_len;
        logic [skgi_pkg::WORD_W-1:0]      want_first;
    } plan_row_t;

    localparam int N_ROWS = 24;
    localparam plan_row_t DIRECTED [N_ROWS] = '{
        // no walk after reset, then a 3-word sentence walked to its end
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 9'd3,    1'b1, 1'b1, 4'd2, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'h1FF,  1'b1, 1'b1, 4'd2, 8'd1},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'h1FF,  1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b1, 1'b0, 4'd0, 8'd0},
        // sentence shorter than the gram, exactly the gram, empty
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 9'd1,    1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 9'd2,    1'b1, 1'b1, 4'd2, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 9'd0,    1'b1, 1'b0, 4'd0, 8'd0},
        // largest gram and skip, word count clamped
        '{1'b1, 4'd8,  8'd255, 1'b0, 1'b1, 9'h1FF,  1'b1, 1'b1, 4'd8, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd17,   1'b0, 1'b0, 4'd0, 8'd0},
        // gram size above the maximum, all lengths
        '{1'b1, 4'd15, 8'd0,   1'b1, 1'b1, 9'd256,  1'b1, 1'b1, 4'd8, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b1, 1'b1, 4'd7, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b0, 1'b0, 4'd0, 8'd0},
        // registers changed while the walk is in progress
        '{1'b1, 4'd3,  8'd2,   1'b0, 1'b0, 9'd0,    1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b0, 1'b0, 4'd0, 8'd0},
        // zero gram size in both modes
        '{1'b1, 4'd0,  8'd4,   1'b0, 1'b1, 9'd5,    1'b1, 1'b0, 4'd0, 8'd0},
        '{1'b1, 4'd0,  8'd4,   1'b1, 1'b1, 9'd5,    1'b1, 1'b0, 4'd0, 8'd0},
        // single-word grams, then an all-lengths walk and a sentence below the largest gram
        '{1'b1, 4'd1,  8'd0,   1'b0, 1'b1, 9'd256,  1'b1, 1'b1, 4'd1, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b1, 1'b1, 4'd1, 8'd1},
        '{1'b1, 4'd4,  8'd1,   1'b1, 1'b1, 9'd7,    1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 9'd0,    1'b0, 1'b0, 4'd0, 8'd0},
        '{1'b1, 4'd8,  8'd255, 1'b0, 1'b1, 9'd7,    1'b1, 1'b0, 4'd0, 8'd0}
    };

    logic                               clk;
    logic                               rst_n       = 1'b0;
    logic                               in_valid    = 1'b0;
    logic                               in_stall;
    logic                               restart     = 1'b0;
    logic [skgi_pkg::COUNT_W-1:0]       word_count  = '0;
    logic                               out_valid;
    logic                               out_stall   = 1'b0;
    logic                               gram_valid;
    logic                               walk_done;
    logic [skgi_pkg::LEN_W-1:0]         gram_length;
    logic [skgi_pkg::WORD_W-1:0]        word_a, word_b, word_c, word_d;
    logic [skgi_pkg::WORD_W-1:0]        word_e, word_f, word_g, word_h;
    logic                               cfg_valid   = 1'b0;
    logic                               cfg_ready;
    logic [skgi_pkg::CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [skgi_pkg::CFG_DAT_W-1:0]     cfg_data    = '0;

    skip_gram_index_enumerator_top #(
        .MAX_GRAM  (MAX_GRAM),
        .MAX_WORDS (MAX_WORDS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .word_count  (word_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .gram_valid  (gram_valid),
        .walk_done   (walk_done),
        .gram_length (gram_length),
        .word_a      (word_a),
        .word_b      (word_b),
        .word_c      (word_c),
        .word_d      (word_d),
        .word_e      (word_e),
        .word_f      (word_f),
        .word_g      (word_g),
        .word_h      (word_h),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- walker
    logic [skgi_pkg::WORD_W-1:0]  walk_stack [MAX_GRAM];
    logic [skgi_pkg::LEN_W-1:0]   walk_depth  = 4'd1;
    logic [skgi_pkg::COUNT_W-1:0] walk_words  = '0;
    bit                           walk_live   = 1'b0;
    logic [skgi_pkg::GRAM_W-1:0]  reg_gram    = 4'd2;
    logic [skgi_pkg::SKIP_W-1:0]  reg_skip    = '0;
    bit                           reg_all     = 1'b0;

    gram_result_t pending_grams [$];
    int           mismatches    = 0;
    int           cycles        = 0;
    int           burst_left    = 0;
    int           n_grams       = 0;
    int           n_exhausted   = 0;
    int           n_restarts    = 0;
    int           n_settings    = 0;

    initial
    begin
        foreach (walk_stack[i])
            walk_stack[i] = '0;
    end

    // Advance the depth-first walk to the next included gram.
    function automatic gram_result_t next_gram(bit rs, logic [skgi_pkg::COUNT_W-1:0] cnt);
        gram_result_t res;
        int           g;
        int           d;
        bit           go;
        bit           hit;
        res = '0;
        g = (reg_gram > MAX_GRAM) ? MAX_GRAM : int'(reg_gram);
        if (rs)
        begin
            walk_words = (cnt > MAX_WORDS) ? skgi_pkg::COUNT_W'(MAX_WORDS) : cnt;
            foreach (walk_stack[i])
                walk_stack[i] = '0;
            walk_depth = 4'd1;
            walk_live  = (int'(walk_words) >= g);
            n_restarts++;
        end
        while (walk_live)
        begin
            d  = int'(walk_depth);
            go = 1'b0;
            if (d < g && d < MAX_GRAM && int'(walk_stack[d]) + 1 < int'(walk_words))
            begin
                if (d == 0)
                    go = 1'b1;
                else
                    go = (int'(walk_stack[d]) - int'(walk_stack[d-1]) <= int'(reg_skip));
            end
            if (go)
            begin
                walk_stack[d] = walk_stack[d] + 1'b1;
                walk_depth    = walk_depth + 1'b1;
                if (d + 1 < g && d + 1 < MAX_GRAM)
                    walk_stack[d+1] = walk_stack[d];
            end
            else
            begin
                hit = (d != 0) && (reg_all ? (d <= g) : (d == g));
                if (hit)
                begin
                    res.gram_valid = 1'b1;
                    res.gram_len   = skgi_pkg::LEN_W'(d);
                    for (int i = 0; i < d; i++)
                        res.words[i] = walk_stack[i];
                end
                if (d == 0)
                    walk_live = 1'b0;
                else
                    walk_depth = walk_depth - 1'b1;
                if (hit)
                    return res;
            end
        end
        res.walk_done = 1'b1;
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic send_item(input bit rs, input logic [skgi_pkg::COUNT_W-1:0] cnt,
                             input bit typed, input gram_result_t want);
        int           gap;
        gram_result_t predicted;
        gram_result_t expected;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid   <= 1'b1;
        restart    <= rs;
        word_count <= cnt;
        do
            @(posedge clk);
        while (in_stall);
        predicted = next_gram(rs, cnt);
        expected  = typed ? want : predicted;
        pending_grams = {pending_grams, expected};
        burst_left--;
    endtask

    // Hold off the sender until every pending result has been taken.
    task automatic drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pending_grams.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [skgi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [skgi_pkg::CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            skgi_pkg::REG_GRAM_SIZE:   reg_gram = data[skgi_pkg::GRAM_W-1:0];
            skgi_pkg::REG_SKIP_LIMIT:  reg_skip = data[skgi_pkg::SKIP_W-1:0];
            skgi_pkg::REG_ALL_LENGTHS: reg_all  = data[0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [skgi_pkg::GRAM_W-1:0] gram,
                               input logic [skgi_pkg::SKIP_W-1:0] skip, input bit all);
        drain();
        write_reg(skgi_pkg::REG_GRAM_SIZE, skgi_pkg::CFG_DAT_W'(gram));
        write_reg(skgi_pkg::REG_SKIP_LIMIT, skip);
        write_reg(skgi_pkg::REG_ALL_LENGTHS, skgi_pkg::CFG_DAT_W'(all));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Receiver stalls in modes of random length, from never to mostly.
    initial
    begin
        int span;
        int pct;
        forever
        begin
            span = $urandom_range(20, 200);
            case ($urandom_range(3))
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                default: pct = 85;
            endcase
            repeat (span)
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    // ---------------------------------------------------------------- checker
    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
                         want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        gram_result_t          want;
        skgi_pkg::gram_words_t got_words;
        if (rst_n && out_valid && !out_stall)
        begin
            got_words = {word_h, word_g, word_f, word_e, word_d, word_c, word_b, word_a};
            if (pending_grams.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result item with none expected", $realtime);
            end
            else
            begin
                want = pending_grams.pop_front();
                check_field("gram_valid", int'(want.gram_valid), int'(gram_valid));
                check_field("walk_done", int'(want.walk_done), int'(walk_done));
                check_field("gram_length", int'(want.gram_len), int'(gram_length));
                for (int i = 0; i < skgi_pkg::OUT_WORDS; i++)
                    check_field($sformatf("word_%c", 8'h61 + i), int'(want.words[i]),
                                int'(got_words[i]));
            end
            if (gram_valid)
                n_grams++;
            else
                n_exhausted++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_grams.size());
            $display("[skip_gram_index_enumerator_top] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial
    begin
        gram_result_t                 want;
        int                           sent;
        int                           pulls;
        bit                           keep_walk;
        bit                           rs;
        logic [skgi_pkg::GRAM_W-1:0]  gram;
        logic [skgi_pkg::SKIP_W-1:0]  skip;
        logic [skgi_pkg::COUNT_W-1:0] cnt;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].set_cfg)
                load_config(DIRECTED[r].gram, DIRECTED[r].skip, DIRECTED[r].all);
            want = '0;
            want.gram_valid = DIRECTED[r].want_gram;
            want.walk_done  = !DIRECTED[r].want_gram;
            want.gram_len   = DIRECTED[r].want_len;
            for (int i = 0; i < int'(DIRECTED[r].want_len); i++)
                want.words[i] = DIRECTED[r].want_first + skgi_pkg::WORD_W'(i);
            send_item(DIRECTED[r].restart, DIRECTED[r].count, DIRECTED[r].typed, want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(5))
                0:       gram = 4'd1;
                1:       gram = 4'd8;
                2:       gram = ($urandom_range(3) == 0) ? 4'd0 : 4'd15;
                default: gram = skgi_pkg::GRAM_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(4))
                0:       skip = 8'd0;
                1:       skip = 8'd255;
                2:       skip = skgi_pkg::SKIP_W'($urandom_range(0, 255));
                default: skip = skgi_pkg::SKIP_W'($urandom_range(0, 3));
            endcase
            load_config(gram, skip, 1'($urandom_range(1)));
            // keep the current walk going under the new settings now and then
            keep_walk = ($urandom_range(3) == 0);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(9))
                    0, 1:    cnt = skgi_pkg::COUNT_W'($urandom_range(0, 256));
                    2:       cnt = skgi_pkg::COUNT_W'($urandom_range(257, 511));
                    default: cnt = skgi_pkg::COUNT_W'($urandom_range(0, 14));
                endcase
                pulls = $urandom_range(1, 40);
                for (int p = 0; p < pulls; p++)
                begin
                    rs = (p == 0) && !keep_walk;
                    if (rs)
                        send_item(1'b1, cnt, 1'b0, '0);
                    else if ($urandom_range(19) == 0)
                        send_item(1'($urandom_range(1)), skgi_pkg::COUNT_W'($urandom),
                                  1'b0, '0);
                    else
                        send_item(1'b0, skgi_pkg::COUNT_W'($urandom), 1'b0, '0);
                    sent++;
                end
                keep_walk = 1'b0;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d register settings and %0d restarts in %0d cycles",
                 n_settings, n_restarts, cycles);
        $display("checked %0d grams and %0d exhausted results, %0d field mismatches",
                 n_grams, n_exhausted, mismatches);
        if (mismatches == 0 && pending_grams.size() == 0)
            $display("[skip_gram_index_enumerator_top] OK");
        else
            $display("[skip_gram_index_enumerator_top] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/skgi_pkg.sv
src/skgi_walk.sv
src/skgi_ctrl.sv
src/skip_gram_index_enumerator_top.sv
test/testbench.sv
